[hdl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int ELEM_W    = 32;
  // matrix terms: candidates need 35 bits, pair sums and differences 33
  localparam int CAND_W    = 35;
  localparam int PAIR_W    = 33;
  localparam int POS_W     = 6;
  // the largest block-scaled magnitude lies in [2^30, 2^31), the others below it
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QUO_W     = FRAC_BITS;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] q_w;
    logic signed [ELEM_W-1:0] q_x;
    logic signed [ELEM_W-1:0] q_y;
    logic signed [ELEM_W-1:0] q_z;
  } quat_t;

  // scaled vector: magnitudes with signs kept apart
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
  } vec_t;

  typedef struct packed {
    vec_t              vec;
    logic [ROOT_W-1:0] root;
  } norm_t;

endpackage

[hdl/rmq_prep.sv]
// Front end: candidates, largest pick, vector build and block scaling (4 stages).
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::mat_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::vec_t out_data
);
  import rmq_pkg::*;

  localparam logic signed [CAND_W-1:0] ONE = CAND_W'(1) << FRAC_BITS;
  localparam int TOP = MAG_W - 1;

  logic [3:0] vld;
  logic [4:0] en;

  // stage 0
  logic signed [CAND_W-1:0] t0 [4];
  logic signed [PAIR_W-1:0] d_x, d_y, d_z, s_xy, s_xz, s_yz;
  logic signed [CAND_W-1:0] e00, e11, e22;
  // stage 1
  logic [CAND_W-1:0]        mag1 [4];
  logic [3:0]               neg1;
  logic [1:0]               pick;
  logic signed [CAND_W-1:0] v [4];
  logic [CAND_W-1:0]        mag_c [4];
  // stage 2
  logic [CAND_W-1:0]        mag2 [4];
  logic [3:0]               neg2;
  logic [POS_W-1:0]         pos2;
  logic [CAND_W-1:0]        big;
  logic [POS_W-1:0]         pos_c;
  // stage 3
  vec_t                     vec3;
  vec_t                     vec_c;
  logic [POS_W-1:0]         sh;

  assign en[4] = out_ready;
  generate
    for (genvar i = 0; i < 4; i++) begin : g_en
      assign en[i] = ~vld[i] | en[i+1];
    end
  endgenerate
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  assign e00 = CAND_W'(in_data.m00);
  assign e11 = CAND_W'(in_data.m11);
  assign e22 = CAND_W'(in_data.m22);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0[0] <= ONE + e00 + e11 + e22;
      t0[1] <= ONE + e00 - e11 - e22;
      t0[2] <= ONE - e00 + e11 - e22;
      t0[3] <= ONE - e00 - e11 + e22;
      d_x   <= PAIR_W'(in_data.m21) - PAIR_W'(in_data.m12);
      d_y   <= PAIR_W'(in_data.m02) - PAIR_W'(in_data.m20);
      d_z   <= PAIR_W'(in_data.m10) - PAIR_W'(in_data.m01);
      s_xy  <= PAIR_W'(in_data.m10) + PAIR_W'(in_data.m01);
      s_xz  <= PAIR_W'(in_data.m02) + PAIR_W'(in_data.m20);
      s_yz  <= PAIR_W'(in_data.m21) + PAIR_W'(in_data.m12);
    end
  end

  // largest candidate, lower index wins a tie
  always_comb begin
    pick = 2'd0;
    if (t0[1] > t0[pick]) pick = 2'd1;
    if (t0[2] > t0[pick]) pick = 2'd2;
    if (t0[3] > t0[pick]) pick = 2'd3;
  end

  always_comb begin
    case (pick)
      2'd0: begin
        v[0] = t0[0];            v[1] = CAND_W'(d_x);
        v[2] = CAND_W'(d_y);     v[3] = CAND_W'(d_z);
      end
      2'd1: begin
        v[0] = CAND_W'(d_x);     v[1] = t0[1];
        v[2] = CAND_W'(s_xy);    v[3] = CAND_W'(s_xz);
      end
      2'd2: begin
        v[0] = CAND_W'(d_y);     v[1] = CAND_W'(s_xy);
        v[2] = t0[2];            v[3] = CAND_W'(s_yz);
      end
      default: begin
        v[0] = CAND_W'(d_z);     v[1] = CAND_W'(s_xz);
        v[2] = CAND_W'(s_yz);    v[3] = t0[3];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = v[i][CAND_W-1] ? CAND_W'(-v[i]) : CAND_W'(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= v[i][CAND_W-1];
      end
    end
  end

  // position of the leading one of the largest magnitude
  always_comb begin
    big = mag1[0];
    for (int i = 1; i < 4; i++) begin
      if (mag1[i] > big) big = mag1[i];
    end
    pos_c = '0;
    for (int b = 0; b < CAND_W; b++) begin
      if (big[b]) pos_c = POS_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag2 <= mag1;
      neg2 <= neg1;
      pos2 <= pos_c;
    end
  end

  // common shift brings the leading one to bit 30; right shift truncates
  always_comb begin
    sh = (pos2 >= POS_W'(TOP)) ? pos2 - POS_W'(TOP) : POS_W'(TOP) - pos2;
    vec_c.neg = neg2;
    for (int i = 0; i < 4; i++) begin
      if (pos2 >= POS_W'(TOP)) vec_c.mag[i] = MAG_W'(mag2[i] >> sh);
      else                     vec_c.mag[i] = MAG_W'(mag2[i] << sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) vec3 <= vec_c;
  end

  assign out_valid = vld[3];
  assign out_data  = vec3;

endmodule

[hdl/rmq_sqrt.sv]
// Norm unit: squares, sum, then a 32-stage digit-by-digit integer square root.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmq_pkg::vec_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmq_pkg::norm_t out_data
);
  import rmq_pkg::*;

  localparam int NS = ROOT_W + 2;

  logic [NS-1:0] vld;
  logic [NS:0]   en;

  vec_t              vec [NS];
  logic [SQ_W-1:0]   sq [4];
  logic [SUM_W-1:0]  rad [ROOT_W+1];
  logic [REM_W-1:0]  rem [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];

  assign en[NS] = out_ready;
  generate
    for (genvar i = 0; i < NS; i++) begin : g_en
      assign en[i] = ~vld[i] | en[i+1];
    end
  endgenerate
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec[0] <= in_data;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= SQ_W'(in_data.mag[i]) * SQ_W'(in_data.mag[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vec[1]  <= vec[0];
      rad[0]  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  // one result bit per stage, two radicand bits taken each time
  generate
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W+1:0] cur, trial;
      assign cur   = {rem[k], rad[k][SUM_W-1-2*k -: 2]};
      assign trial = (REM_W+2)'({root[k], 2'b01});
      always_ff @(posedge clk) begin
        if (en[k+2]) begin
          vec[k+2] <= vec[k+1];
          rad[k+1] <= rad[k];
          if (cur >= trial) begin
            rem[k+1]  <= REM_W'(cur - trial);
            root[k+1] <= {root[k][ROOT_W-2:0], 1'b1};
          end else begin
            rem[k+1]  <= REM_W'(cur);
            root[k+1] <= {root[k][ROOT_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign out_valid     = vld[NS-1];
  assign out_data.vec  = vec[NS-1];
  assign out_data.root = root[ROOT_W];

endmodule

[hdl/rmq_div.sv]
// Divide unit: four restoring dividers, one quotient bit per stage, then round and sign.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmq_pkg::norm_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rmq_pkg::quat_t out_data
);
  import rmq_pkg::*;

  localparam int NS = QUO_W + 1;

  logic [NS-1:0] vld;
  logic [NS:0]   en;

  logic [3:0][ROOT_W-1:0] rr [1:QUO_W];
  logic [3:0][QUO_W-1:0]  qq [1:QUO_W];
  logic [ROOT_W-1:0]      nn [1:QUO_W];
  logic [3:0]             ng [1:QUO_W];
  logic [3:0][QUO_W:0]    qr;
  quat_t                  res;

  assign en[NS] = out_ready;
  generate
    for (genvar i = 0; i < NS; i++) begin : g_en
      assign en[i] = ~vld[i] | en[i+1];
    end
  endgenerate
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  generate
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [3:0][ROOT_W-1:0] rs;
      logic [3:0][QUO_W-1:0]  qs;
      logic [ROOT_W-1:0]      nd;
      logic [3:0]             gs;
      logic [3:0][ROOT_W:0]   r2;
      if (k == 0) begin : g_first
        assign nd = in_data.root;
        assign gs = in_data.vec.neg;
        assign qs = '0;
        for (genvar i = 0; i < 4; i++) begin : g_mag
          assign rs[i] = ROOT_W'(in_data.vec.mag[i]);
        end
      end else begin : g_next
        assign nd = nn[k];
        assign gs = ng[k];
        assign qs = qq[k];
        assign rs = rr[k];
      end
      always_comb begin
        for (int i = 0; i < 4; i++) r2[i] = {rs[i], 1'b0};
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          nn[k+1] <= nd;
          ng[k+1] <= gs;
          for (int i = 0; i < 4; i++) begin
            if (r2[i] >= (ROOT_W+1)'(nd)) begin
              rr[k+1][i] <= ROOT_W'(r2[i] - (ROOT_W+1)'(nd));
              qq[k+1][i] <= {qs[i][QUO_W-2:0], 1'b1};
            end else begin
              rr[k+1][i] <= ROOT_W'(r2[i]);
              qq[k+1][i] <= {qs[i][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
    end
  endgenerate

  // round half up; magnitude never exceeds 2^30 here
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qr[i] = (QUO_W+1)'(qq[QUO_W][i]) +
              (QUO_W+1)'({rr[QUO_W][i], 1'b0} >= (ROOT_W+1)'(nn[QUO_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res.q_w <= ng[QUO_W][0] ? -ELEM_W'(qr[0]) : ELEM_W'(qr[0]);
      res.q_x <= ng[QUO_W][1] ? -ELEM_W'(qr[1]) : ELEM_W'(qr[1]);
      res.q_y <= ng[QUO_W][2] ? -ELEM_W'(qr[2]) : ELEM_W'(qr[2]);
      res.q_z <= ng[QUO_W][3] ? -ELEM_W'(qr[3]) : ELEM_W'(qr[3]);
    end
  end

  assign out_valid = vld[NS-1];
  assign out_data  = res;

endmodule

[hdl/rotation_matrix_to_quaternion_top.sv]
// Top level: rotation matrix (Q2.30) to unit quaternion (Q2.30), Shepperd's method.
// Depends on rmq_pkg, rmq_prep, rmq_sqrt, rmq_div.
//
//   port group                    dir  word
//   mat_valid/mat_ready/mat       in   nine matrix elements, mat_t
//   quat_valid/quat_ready/quat    out  q_w q_x q_y q_z, quat_t
//
// One word a cycle in while quat_ready is high: 4 front-end stages, 34 norm stages
// (squares, sum, one square-root bit per stage) and 31 divider stages (one
// quotient bit per stage, then rounding).
// rst is synchronous and clears only the stage valid bits.
// A stage loads whenever it is empty or the one after it moves, so a stalled
// output holds its word while earlier stages keep filling the gaps.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  output logic           mat_ready,
  input  rmq_pkg::mat_t  mat,
  output logic           quat_valid,
  input  logic           quat_ready,
  output rmq_pkg::quat_t quat
);
  import rmq_pkg::*;

  logic  pv_valid, pv_ready;
  vec_t  pv_data;
  logic  nr_valid, nr_ready;
  norm_t nr_data;

  rmq_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_data   (mat),
    .out_valid (pv_valid),
    .out_ready (pv_ready),
    .out_data  (pv_data)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv_valid),
    .in_ready  (pv_ready),
    .in_data   (pv_data),
    .out_valid (nr_valid),
    .out_ready (nr_ready),
    .out_data  (nr_data)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nr_valid),
    .in_ready  (nr_ready),
    .in_data   (nr_data),
    .out_valid (quat_valid),
    .out_ready (quat_ready),
    .out_data  (quat)
  );

endmodule
